>>> rtl/dht_pkg.sv
package dht_pkg;

    localparam int SLOTS      = 13;
    localparam int STEP_PRIME = 7;

    localparam int OP_W     = 1;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int PROBE_W  = SLOT_W;
    localparam int COUNT_W  = $clog2(SLOTS + 1);

    localparam int MOD_MAX = (SLOTS > STEP_PRIME) ? SLOTS : STEP_PRIME;
    localparam int REM_W   = $clog2(MOD_MAX + 1);

    localparam int CHUNK_W     = 8;
    localparam int KEY_CHUNKS  = (KEY_W + CHUNK_W - 1) / CHUNK_W;
    localparam int KEY_PAD_W   = KEY_CHUNKS * CHUNK_W;
    localparam int STEP_W      = $clog2(STEP_PRIME + 1);
    localparam int STEP_CHUNKS = (STEP_W + CHUNK_W - 1) / CHUNK_W;
    localparam int STEP_PAD_W  = STEP_CHUNKS * CHUNK_W;
    localparam int MAX_CHUNKS  = (KEY_CHUNKS > STEP_CHUNKS) ? KEY_CHUNKS : STEP_CHUNKS;
    localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] step;
    } dht_req_t;

    typedef struct packed {
        logic push;
        logic full;
    } dht_push_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } dht_pop_ctl_t;

    function automatic logic [REM_W-1:0] mod_chunk(
        input logic [REM_W-1:0]   r,
        input logic [CHUNK_W-1:0] b,
        input logic [REM_W-1:0]   m
    );
        logic [REM_W:0] t;
        t = {1'b0, r};
        for (int j = CHUNK_W - 1; j >= 0; j--)
        begin
            t = {t[REM_W-1:0], b[j]};
            if (t >= {1'b0, m})
            begin
                t = t - {1'b0, m};
            end
        end
        return t[REM_W-1:0];
    endfunction

endpackage

>>> rtl/dht_hash.sv
module dht_hash (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [dht_pkg::KEY_W-1:0]   key,
    output logic                        push,
    input  logic                        full,
    output dht_pkg::dht_req_t           push_entry
);
    import dht_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_STEP_INIT,
        S_STEP,
        S_PUSH
    } state_t;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [KEY_PAD_W-1:0]     key_sh_reg, key_sh_next;
    logic [STEP_PAD_W-1:0]    step_sh_reg, step_sh_next;
    logic [REM_W-1:0]         rs_reg, rs_next;
    logic [REM_W-1:0]         rp_reg, rp_next;
    logic [REM_W-1:0]         rt_reg, rt_next;
    logic [CHUNK_CNT_W-1:0]   cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);
    assign push     = (state_reg == S_PUSH);

    assign push_entry.op   = op_reg;
    assign push_entry.key  = key_reg;
    assign push_entry.pos  = rs_reg[SLOT_W-1:0];
    assign push_entry.step = rt_reg[SLOT_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        key_sh_next  = key_sh_reg;
        step_sh_next = step_sh_reg;
        rs_next      = rs_reg;
        rp_next      = rp_reg;
        rt_next      = rt_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(operation);
                    key_next    = key;
                    key_sh_next = KEY_PAD_W'(key);
                    rs_next     = '0;
                    rp_next     = '0;
                    cnt_next    = '0;
                    state_next  = S_KEY;
                end
            end
            S_KEY:
            begin
                rs_next = mod_chunk(rs_reg, key_sh_reg[KEY_PAD_W-1 -: CHUNK_W],
                                    REM_W'(SLOTS));
                rp_next = mod_chunk(rp_reg, key_sh_reg[KEY_PAD_W-1 -: CHUNK_W],
                                    REM_W'(STEP_PRIME));
                key_sh_next = key_sh_reg << CHUNK_W;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CHUNK_CNT_W'(KEY_CHUNKS - 1))
                begin
                    state_next = S_STEP_INIT;
                end
            end
            S_STEP_INIT:
            begin
                step_sh_next = STEP_PAD_W'(STEP_PRIME) - STEP_PAD_W'(rp_reg);
                rt_next      = '0;
                cnt_next     = '0;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                rt_next = mod_chunk(rt_reg, step_sh_reg[STEP_PAD_W-1 -: CHUNK_W],
                                    REM_W'(SLOTS));
                step_sh_next = step_sh_reg << CHUNK_W;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CHUNK_CNT_W'(STEP_CHUNKS - 1))
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        key_sh_reg  <= key_sh_next;
        step_sh_reg <= step_sh_next;
        rs_reg      <= rs_next;
        rp_reg      <= rp_next;
        rt_reg      <= rt_next;
        cnt_reg     <= cnt_next;
    end

endmodule

>>> rtl/dht_fifo.sv
module dht_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dht_pkg::dht_push_ctl_t wr_ctl_in,
    output logic                  full,
    input  dht_pkg::dht_req_t     wr_entry,
    input  logic                  pop,
    output logic                  empty,
    output dht_pkg::dht_req_t     rd_entry
);
    import dht_pkg::*;

    dht_req_t                entries [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    do_push, do_pop;

    assign full     = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign rd_entry = entries[rd_ptr_reg];
    assign do_push  = wr_ctl_in.push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> rtl/dht_probe.sv
module dht_probe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dht_pkg::dht_req_t             req,
    output dht_pkg::dht_pop_ctl_t         rd_ctl,
    input  logic                          empty,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dht_pkg::STATUS_W-1:0]  status,
    output logic [dht_pkg::SLOT_W-1:0]    slot,
    output logic [dht_pkg::PROBE_W-1:0]   probe_number,
    output logic [dht_pkg::COUNT_W-1:0]   fill_count
);
    import dht_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [SLOT_W-1:0]    pos_reg, pos_next;
    logic [SLOT_W-1:0]    step_reg, step_next;
    logic [PROBE_W-1:0]   probe_reg, probe_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [PROBE_W-1:0]   probe_out_reg, probe_out_next;
    logic [COUNT_W-1:0]   fill_reg, fill_next;

    logic [KEY_W-1:0]     slot_keys [0:SLOTS-1];
    logic [KEY_W-1:0]     rd_key_reg;

    logic [SLOT_W:0]      pos_sum;
    logic [SLOT_W-1:0]    pos_adv;
    logic                 out_free;
    logic                 occupied;
    logic                 last_probe;
    logic                 table_full;
    logic                 wr_en;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign probe_number = probe_out_reg;
    assign fill_count   = fill_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign occupied   = valid_reg[pos_reg];
    assign last_probe = (probe_reg == PROBE_W'(SLOTS - 1));
    assign table_full = (count_reg == COUNT_W'(SLOTS));
    assign pos_sum    = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_adv    = (pos_sum >= (SLOT_W + 1)'(SLOTS)) ?
                        SLOT_W'(pos_sum - (SLOT_W + 1)'(SLOTS)) : pos_sum[SLOT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        slot_next      = slot_reg;
        probe_out_next = probe_out_reg;
        fill_next      = fill_reg;
        rd_ctl.pop     = 1'b0;
        rd_ctl.empty   = empty;
        wr_en          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    rd_ctl.pop = 1'b1;
                    op_next    = req.op;
                    key_next   = req.key;
                    pos_next   = req.pos;
                    step_next  = req.step;
                    probe_next = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    fill_next      = count_reg;
                    slot_next      = '0;
                    probe_out_next = probe_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        if (table_full)
                        begin
                            status_next    = ST_FULL;
                            probe_out_next = '0;
                        end
                        else if (!occupied)
                        begin
                            status_next         = ST_INSERTED;
                            slot_next           = pos_reg;
                            wr_en               = 1'b1;
                            valid_next[pos_reg] = 1'b1;
                            count_next          = count_reg + 1'b1;
                            fill_next           = count_reg + 1'b1;
                        end
                        else if (last_probe)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            state_next     = S_PROBE;
                            out_valid_next = out_valid_reg && out_stall;
                            status_next    = status_reg;
                            slot_next      = slot_reg;
                            probe_out_next = probe_out_reg;
                            fill_next      = fill_reg;
                            pos_next       = pos_adv;
                            probe_next     = probe_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (!occupied)
                        begin
                            status_next = ST_MISSING;
                            slot_next   = pos_reg;
                        end
                        else if (rd_key_reg == key_reg)
                        begin
                            status_next = ST_FOUND;
                            slot_next   = pos_reg;
                        end
                        else if (last_probe)
                        begin
                            status_next = ST_MISSING;
                        end
                        else
                        begin
                            state_next     = S_PROBE;
                            out_valid_next = out_valid_reg && out_stall;
                            status_next    = status_reg;
                            slot_next      = slot_reg;
                            probe_out_next = probe_out_reg;
                            fill_next      = fill_reg;
                            pos_next       = pos_adv;
                            probe_next     = probe_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        step_reg      <= step_next;
        probe_reg     <= probe_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        probe_out_reg <= probe_out_next;
        fill_reg      <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_keys[pos_reg] <= key_reg;
        end
        rd_key_reg <= slot_keys[pos_next];
    end

endmodule

>>> rtl/double_hash_table.sv
// Flow: the key hasher reduces the key chunk by chunk modulo the table size and the
// step prime and pushes the request into the queue; the probe engine pops it, probes
// 1 to 13 slots, and holds the result in the output register.
// The hasher stalls its input until it has pushed the request; the hasher
// and the probe engine overlap through a two-entry queue.
// Reset: slot valid bits and the fill count clear at once; slot keys are not
// cleared, and a stored key is compared only for an occupied slot.
module double_hash_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [dht_pkg::KEY_W-1:0]     key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dht_pkg::STATUS_W-1:0]  status,
    output logic [dht_pkg::SLOT_W-1:0]    slot,
    output logic [dht_pkg::PROBE_W-1:0]   probe_number,
    output logic [dht_pkg::COUNT_W-1:0]   fill_count
);
    import dht_pkg::*;

    dht_req_t       push_entry;
    dht_req_t       pop_entry;
    dht_push_ctl_t  push_ctl;
    dht_pop_ctl_t   pop_ctl;
    logic           push;
    logic           full;
    logic           empty;

    assign push_ctl.push = push;
    assign push_ctl.full = full;

    dht_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .key        (key),
        .push       (push),
        .full       (full),
        .push_entry (push_entry)
    );

    dht_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_ctl_in (push_ctl),
        .full      (full),
        .wr_entry  (push_entry),
        .pop       (pop_ctl.pop),
        .empty     (empty),
        .rd_entry  (pop_entry)
    );

    dht_probe u_probe (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (pop_entry),
        .rd_ctl       (pop_ctl),
        .empty        (empty),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot         (slot),
        .probe_number (probe_number),
        .fill_count   (fill_count)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("hasher took a beat without going busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_count <= COUNT_W'(SLOTS)))
        else $error("fill count above table size");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_INSERTED || status == ST_FOUND))
            |-> (slot < SLOT_W'(SLOTS)))
        else $error("result slot out of range");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (slot == '0 && fill_count == COUNT_W'(SLOTS))
            || (out_valid && status == ST_FULL && slot == '0
                && probe_number == PROBE_W'(SLOTS - 1)))
        else $error("full result with bad slot or count");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ctl.pop |-> !pop_ctl.empty)
        else $error("probe engine popped an empty queue");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dht_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [PROBE_W-1:0]   probe;
        logic [COUNT_W-1:0]   fill;
    } lookup_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = 1'b0;
    logic [KEY_W-1:0]      key = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [PROBE_W-1:0]    probe_number;
    logic [COUNT_W-1:0]    fill_count;

    logic [KEY_W-1:0]      shadow_keys [SLOTS];
    logic                  shadow_valid [SLOTS];
    int unsigned           shadow_fill = 0;

    lookup_result_t        pending_results [$];
    lookup_result_t        head;
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_idle_pct = 0;

    double_hash_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .key          (key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot         (slot),
        .probe_number (probe_number),
        .fill_count   (fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            shadow_valid[s] = 1'b0;
            shadow_keys[s] = '0;
        end
    end

    function automatic lookup_result_t apply_request(input op_t op, input logic [KEY_W-1:0] k);
        lookup_result_t r;
        int unsigned    pos;
        int unsigned    step;
        r.status = (op == OP_INSERT) ? ST_FULL : ST_MISSING;
        r.slot = '0;
        r.probe = PROBE_W'(SLOTS - 1);
        pos = k % SLOTS;
        step = STEP_PRIME - k % STEP_PRIME;
        if (op == OP_INSERT && shadow_fill >= SLOTS)
        begin
            r.probe = '0;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!shadow_valid[pos])
                begin
                    if (op == OP_INSERT)
                    begin
                        shadow_keys[pos] = k;
                        shadow_valid[pos] = 1'b1;
                        shadow_fill++;
                        r.status = ST_INSERTED;
                    end
                    r.slot = SLOT_W'(pos);
                    r.probe = PROBE_W'(i);
                    break;
                end
                if (op == OP_SEARCH && shadow_keys[pos] == k)
                begin
                    r.status = ST_FOUND;
                    r.slot = SLOT_W'(pos);
                    r.probe = PROBE_W'(i);
                    break;
                end
                pos = (pos + step) % SLOTS;
            end
        end
        r.fill = COUNT_W'(shadow_fill);
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'($urandom());
    endfunction

    // Any key whose first probe lands on slot s.
    function automatic logic [KEY_W-1:0] key_at_slot(input int unsigned s);
        return KEY_W'(s + SLOTS * $urandom_range((32'h7FFF_FFFF - s) / SLOTS, 0));
    endfunction

    function automatic logic [KEY_W-1:0] stored_key();
        int unsigned s;
        s = $urandom_range(SLOTS - 1);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (shadow_valid[s])
            begin
                return shadow_keys[s];
            end
            s = (s + 1) % SLOTS;
        end
        return rand_key();
    endfunction

    function automatic logic [KEY_W-1:0] search_key();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            return stored_key();
        end
        else if (pick < 8)
        begin
            return key_at_slot($urandom_range(SLOTS - 1));
        end
        return rand_key();
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(input op_t op, input logic [KEY_W-1:0] k);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        operation <= op;
        key <= k;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_results.push_back(apply_request(op, k));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending: status %0d slot %0d",
                       status, slot);
                error_count++;
            end
            else
            begin
                head = pending_results.pop_front();
                check_field("status", head.status, status);
                check_field("slot", head.slot, slot);
                check_field("probe_number", head.probe, probe_number);
                check_field("fill_count", head.fill, fill_count);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_search_empty();
        send_item(OP_SEARCH, '0);
        send_item(OP_SEARCH, KEY_MAX);
        send_item(OP_SEARCH, key_at_slot(5));
    endtask

    task automatic test_insert_probing();
        send_item(OP_INSERT, KEY_W'(0));
        send_item(OP_INSERT, KEY_W'(13));
        send_item(OP_INSERT, KEY_W'(26));
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_INSERT, KEY_W'(13));
        send_item(OP_INSERT, key_at_slot(0));
        send_item(OP_SEARCH, KEY_W'(13));
        send_item(OP_SEARCH, KEY_W'(26));
        send_item(OP_SEARCH, KEY_W'(39));
        send_item(OP_SEARCH, KEY_MAX);
        // hold off until the pipeline is empty
        wait_for_results();
        send_item(OP_SEARCH, KEY_W'(0));
    endtask

    task automatic test_sparse_traffic(input int unsigned count);
        repeat (count)
        begin
            if (shadow_fill < SLOTS && $urandom_range(99) < 2)
            begin
                send_item(OP_INSERT, $urandom_range(1) ? rand_key()
                                                       : key_at_slot($urandom_range(SLOTS - 1)));
            end
            else
            begin
                send_item(OP_SEARCH, search_key());
            end
        end
    endtask

    task automatic test_fill_to_capacity();
        while (shadow_fill < SLOTS)
        begin
            send_item(OP_INSERT, key_at_slot($urandom_range(SLOTS - 1)));
        end
        send_item(OP_INSERT, stored_key());
        send_item(OP_SEARCH, rand_key());
        send_item(OP_SEARCH, stored_key());
    endtask

    task automatic test_full_traffic(input int unsigned count);
        repeat (count)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_item(OP_INSERT, $urandom_range(1) ? rand_key() : stored_key());
            end
            else
            begin
                send_item(OP_SEARCH, search_key());
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 33;
        recv_idle_pct = 80;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_search_empty();
        test_insert_probing();
        test_sparse_traffic(520);
        test_fill_to_capacity();

        send_idle_pct = 80;
        recv_idle_pct = 33;
        test_full_traffic(500);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_traffic(500);

        wait_for_results();
        repeat (30) @(negedge clk);
        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
